// ===== design/sprq_pkg.sv =====
package sprq_pkg;

  // Command codes carried on s_tuser
  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_PURGE   = 2'd2
  } cmd_t;

  // Result status carried on m_tuser
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Controller -> datapath
  typedef struct packed {
    logic    enq;         // insert the new entry in sorted position
    logic    deq;         // drop the head, shift the row down
    logic    scan_start;  // latch purge id, clear scan pointer
    logic    scan_step;   // examine one cell of the purge scan
    logic    load_now;    // load result register from this cycle's operation
    logic    load_scan;   // load result register at the end of a purge scan
    status_t status;      // status for load_now
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic scan_last;  // scan pointer sits on the last valid entry
  } dp_stat_t;

endpackage

// ===== design/sprq_datapath.sv =====
module sprq_datapath #(
  parameter int DEPTH = 16,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int PW = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                rst,
  input  sprq_pkg::dp_cmd_t   cmd,
  input  logic [7:0]          in_id,
  input  logic [7:0]          in_prio,
  output sprq_pkg::dp_stat_t  stat,
  output sprq_pkg::status_t   out_status,
  output logic [7:0]          out_id,
  output logic [7:0]          out_prio,
  output logic [CW-1:0]       out_count,
  output logic                out_empty
);
  import sprq_pkg::*;

  // Row of cells, head at index 0
  logic [7:0]    ids [DEPTH];
  logic [7:0]    pri [DEPTH];
  logic [CW-1:0] count;

  // Purge scan state
  logic [PW-1:0] ptr;
  logic          found;
  logic [7:0]    sid;
  logic [7:0]    rid;
  logic [7:0]    rprio;

  logic [DEPTH-1:0] ins;       // cell at or after the insertion point
  logic [DEPTH-1:0] ins_prev;
  logic [7:0]       prv_id  [DEPTH];
  logic [7:0]       prv_pri [DEPTH];
  logic [7:0]       nxt_id  [DEPTH];
  logic [7:0]       nxt_pri [DEPTH];

  logic          hit;
  logic          shift_scan;
  logic [CW-1:0] count_now;
  logic [CW-1:0] count_scan;

  // Sorted row makes "new prio < cell prio" monotonic, so each cell
  // decides locally whether it takes the new item or its lower neighbor.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ins[i] = ((CW'(i) < count) && (in_prio < pri[i])) || (CW'(i) == count);
    end
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_nbr
      if (g == 0) begin : g_head
        assign ins_prev[g] = 1'b0;
        assign prv_id[g]   = in_id;
        assign prv_pri[g]  = in_prio;
      end else begin : g_body
        assign ins_prev[g] = ins[g-1];
        assign prv_id[g]   = ids[g-1];
        assign prv_pri[g]  = pri[g-1];
      end
      if (g == DEPTH - 1) begin : g_tail
        assign nxt_id[g]  = ids[g];
        assign nxt_pri[g] = pri[g];
      end else begin : g_mid
        assign nxt_id[g]  = ids[g+1];
        assign nxt_pri[g] = pri[g+1];
      end

      always_ff @(posedge clk) begin
        if (cmd.enq) begin
          if (ins_prev[g]) begin
            ids[g] <= prv_id[g];
            pri[g] <= prv_pri[g];
          end else if (ins[g]) begin
            ids[g] <= in_id;
            pri[g] <= in_prio;
          end
        end else if (cmd.deq || (cmd.scan_step && shift_scan && (ptr == PW'(g)))) begin
          ids[g] <= nxt_id[g];
          pri[g] <= nxt_pri[g];
        end
      end
    end
  endgenerate

  assign hit        = !found && (ids[ptr] == sid);
  assign shift_scan = found || hit;

  always_comb begin
    priority if (cmd.enq) begin
      count_now = count + CW'(1);
    end else if (cmd.deq) begin
      count_now = count - CW'(1);
    end else begin
      count_now = count;
    end
  end

  assign count_scan = shift_scan ? (count - CW'(1)) : count;

  assign stat.full      = (count == CW'(DEPTH));
  assign stat.empty     = (count == '0);
  assign stat.scan_last = ((CW'(ptr) + CW'(1)) == count);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ptr   <= '0;
      found <= 1'b0;
    end else begin
      if (cmd.enq || cmd.deq) begin
        count <= count_now;
      end else if (cmd.load_scan) begin
        count <= count_scan;
      end
      if (cmd.scan_start) begin
        ptr   <= '0;
        found <= 1'b0;
      end else if (cmd.scan_step) begin
        ptr <= ptr + PW'(1);
        if (hit) begin
          found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      sid <= in_id;
    end
    if (cmd.scan_step && hit) begin
      rid   <= ids[ptr];
      rprio <= pri[ptr];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_now) begin
      out_status <= cmd.status;
      out_id     <= cmd.deq ? ids[0] : 8'd0;
      out_prio   <= cmd.deq ? pri[0] : 8'd0;
      out_count  <= count_now;
      out_empty  <= (count_now == '0);
    end else if (cmd.load_scan) begin
      out_status <= shift_scan ? ST_OK : ST_NOT_FOUND;
      out_id     <= !shift_scan ? 8'd0 : (hit ? ids[ptr] : rid);
      out_prio   <= !shift_scan ? 8'd0 : (hit ? pri[ptr] : rprio);
      out_count  <= count_scan;
      out_empty  <= (count_scan == '0);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> (CW'(ptr) < count))
    else $error("purge scan past last entry");

  a_enq_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.enq |=> (count == $past(count) + CW'(1)))
    else $error("enqueue did not grow count");

endmodule

// ===== design/sprq_ctrl.sv =====
module sprq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [1:0]          cmd_code,
  output logic                m_tvalid,
  input  logic                m_tready,
  output sprq_pkg::dp_cmd_t   cmd,
  input  sprq_pkg::dp_stat_t  stat
);
  import sprq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd        = '0;
    cmd.status = ST_OK;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_code)
            CMD_ENQUEUE: begin
              cmd.load_now = 1'b1;
              if (stat.full) begin
                cmd.status = ST_FULL;
              end else begin
                cmd.enq = 1'b1;
              end
            end
            CMD_DEQUEUE: begin
              cmd.load_now = 1'b1;
              if (stat.empty) begin
                cmd.status = ST_EMPTY;
              end else begin
                cmd.deq = 1'b1;
              end
            end
            CMD_PURGE: begin
              if (stat.empty) begin
                cmd.load_now = 1'b1;
                cmd.status   = ST_NOT_FOUND;
              end else begin
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN;
              end
            end
            default: begin
              // unused code: report current entry count
              cmd.load_now = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          cmd.load_scan = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_now || cmd.load_scan) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_scan_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !m_tvalid)
    else $error("result pending during purge scan");

  a_single_load: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load_now && cmd.load_scan) && !(cmd.enq && cmd.deq))
    else $error("conflicting datapath commands");

  a_scan_start_enters: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_start |=> (state == S_SCAN))
    else $error("purge start without scan");

endmodule

// ===== design/sorted_priority_ready_queue.sv =====
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tuser: command; s_tdata: proc_id, priority_req
// m_        out  m_tvalid/m_tready  m_tuser: status;  m_tdata: id, prio, count, empty
//
// Enqueue, dequeue and unused codes: result registered at the accept edge.
// Insertion uses per-cell compares and a one-step shift.
// Purge of a non-empty queue: an accept step, then one scan step per stored entry
// (a pointer walks the row from the head); the result loads at the last entry.
// A new transaction is taken when no scan runs and the result register is free
// or being drained the same cycle.
// Synchronous active-high reset empties the queue and drops any pending result.
module sorted_priority_ready_queue #(
  parameter int DEPTH = 16,
  localparam int CW  = $clog2(DEPTH + 1),
  localparam int ODW = ((17 + CW + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [15:0]    s_tdata,   // [7:0] proc_id, [15:8] priority_req
  input  logic [1:0]     s_tuser,   // [1:0] command
  output logic           m_tvalid,
  input  logic           m_tready,
  // [7:0] out_proc_id, [15:8] out_priority, [CW+15:16] entry_count,
  // [CW+16] is_empty, zero fill above
  output logic [ODW-1:0] m_tdata,
  output logic [1:0]     m_tuser    // [1:0] status
);
  import sprq_pkg::*;

  dp_cmd_t       cmd;
  dp_stat_t      stat;
  status_t       out_status;
  logic [7:0]    out_id;
  logic [7:0]    out_prio;
  logic [CW-1:0] out_count;
  logic          out_empty;

  sprq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd_code (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  sprq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_id      (s_tdata[7:0]),
    .in_prio    (s_tdata[15:8]),
    .stat       (stat),
    .out_status (out_status),
    .out_id     (out_id),
    .out_prio   (out_prio),
    .out_count  (out_count),
    .out_empty  (out_empty)
  );

  assign m_tuser = out_status;
  assign m_tdata = ODW'({out_empty, out_count, out_prio, out_id});

endmodule

// ===== bench/sprq_result_checker.sv =====
module sprq_result_checker #(
  parameter int DEPTH = 16,
  localparam int CW  = $clog2(DEPTH + 1),
  localparam int ODW = ((17 + CW + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  input  logic           s_tready,
  input  logic [15:0]    s_tdata,   // [7:0] proc_id, [15:8] priority_req
  input  logic [1:0]     s_tuser,   // [1:0] command
  input  logic           m_tvalid,
  input  logic           m_tready,
  // [7:0] out_proc_id, [15:8] out_priority, [CW+15:16] entry_count,
  // [CW+16] is_empty, zero fill above
  input  logic [ODW-1:0] m_tdata,
  input  logic [1:0]     m_tuser,   // [1:0] status
  output int             n_errors,
  output int             n_pending,
  output int             n_results,
  output int             n_full,
  output int             n_empty,
  output int             n_not_found
);
  timeunit 1ns;
  timeprecision 1ps;

  import sprq_pkg::*;

  typedef struct packed {
    status_t       status;
    logic [7:0]    id;
    logic [7:0]    prio;
    logic [CW-1:0] count;
    logic          empty;
  } result_t;

  // Shadow of the ready queue, head at slot 0
  logic [7:0] slot_id   [DEPTH];
  logic [7:0] slot_prio [DEPTH];
  int         held;

  result_t due_results[$];
  int      errors, results, full_hits, empty_hits, purge_misses;

  initial begin
    held         = 0;
    errors       = 0;
    results      = 0;
    full_hits    = 0;
    empty_hits   = 0;
    purge_misses = 0;
  end

  function automatic void remove_slot(int pos);
    for (int i = pos; i + 1 < held; i++) begin
      slot_id[i]   = slot_id[i + 1];
      slot_prio[i] = slot_prio[i + 1];
    end
    held--;
  endfunction

  function automatic result_t predict_result(logic [1:0] cmd, logic [7:0] id,
                                             logic [7:0] prio);
    result_t r;
    int      pos;
    r        = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_ENQUEUE: begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // first slot holding a strictly larger priority; ties stay FIFO
          pos = held;
          for (int i = held - 1; i >= 0; i--) begin
            if (prio < slot_prio[i]) pos = i;
          end
          for (int i = held; i > pos; i--) begin
            slot_id[i]   = slot_id[i - 1];
            slot_prio[i] = slot_prio[i - 1];
          end
          slot_id[pos]   = id;
          slot_prio[pos] = prio;
          held++;
        end
      end
      CMD_DEQUEUE: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.id   = slot_id[0];
          r.prio = slot_prio[0];
          remove_slot(0);
        end
      end
      CMD_PURGE: begin
        pos = -1;
        for (int i = held - 1; i >= 0; i--) begin
          if (slot_id[i] == id) pos = i;
        end
        if (pos < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.id   = slot_id[pos];
          r.prio = slot_prio[pos];
          remove_slot(pos);
        end
      end
      default: ;  // unused code leaves the queue alone
    endcase
    r.count = CW'(held);
    r.empty = (held == 0);
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      due_results.delete();
      held = 0;
    end else begin
      // result first: it always belongs to an earlier command
      if (m_tvalid && m_tready) begin
        if (due_results.size() == 0) begin
          $error("result with no command waiting: status %0d, tdata 0x%0h",
                 m_tuser, m_tdata);
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("status", want.status, m_tuser);
          check_field("out_proc_id", want.id, m_tdata[7:0]);
          check_field("out_priority", want.prio, m_tdata[15:8]);
          check_field("entry_count", want.count, m_tdata[CW+15:16]);
          check_field("is_empty", want.empty, m_tdata[CW+16]);
          check_field("zero fill", 0, int'(m_tdata >> (CW + 17)));
          results++;
          if (want.status == ST_FULL) full_hits++;
          if (want.status == ST_EMPTY) empty_hits++;
          if (want.status == ST_NOT_FOUND) purge_misses++;
        end
      end
      if (s_tvalid && s_tready) begin
        due_results.push_back(predict_result(s_tuser, s_tdata[7:0], s_tdata[15:8]));
      end
    end
    n_errors    <= errors;
    n_pending   <= due_results.size();
    n_results   <= results;
    n_full      <= full_hits;
    n_empty     <= empty_hits;
    n_not_found <= purge_misses;
  end

endmodule

// ===== bench/sorted_priority_ready_queue_test.sv =====
// Stimulus and verdict for the sorted ready queue. The checker beside the
// block owns prediction and comparison; this module only drives traffic.
module sorted_priority_ready_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sprq_pkg::*;

  localparam int DEPTH = 16;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int ODW   = ((17 + CW + 7) / 8) * 8;

  // Code 3 has no member in cmd_t; the block must treat it as a no-op
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Slowest purge is a full scan of the queue; even with worst gaps and stalls
  // this leaves a wide margin over ~475 items.
  localparam int LIMIT_CYCLES = 200000;
  // Longest in-flight operation (full purge scan) plus slack
  localparam int DRAIN_CYCLES = 40;

  logic           clk      = 1'b0;
  logic           rst      = 1'b1;
  logic           s_tvalid = 1'b0;
  logic           s_tready;
  logic [15:0]    s_tdata  = '0;   // [7:0] proc_id, [15:8] priority_req
  logic [1:0]     s_tuser  = '0;   // [1:0] command
  logic           m_tvalid;
  logic           m_tready = 1'b0;
  logic [ODW-1:0] m_tdata;         // id, priority, count, empty flag, zero fill
  logic [1:0]     m_tuser;         // [1:0] status

  int n_errors, n_pending, n_results, n_full, n_empty, n_not_found;
  int n_sent [4];
  int cycle_count = 0;

  // Switches both sides to back-to-back traffic for whole phases
  bit idle_off = 1'b0;

  always #2 clk = ~clk;

  sorted_priority_ready_queue #(.DEPTH(DEPTH)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  sprq_result_checker #(.DEPTH(DEPTH)) u_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .n_errors    (n_errors),
    .n_pending   (n_pending),
    .n_results   (n_results),
    .n_full      (n_full),
    .n_empty     (n_empty),
    .n_not_found (n_not_found)
  );

  // Idle length: mostly short, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // One input transaction. Valid stays up into the next call unless an
  // idle gap is taken, so back-to-back items never toggle tvalid.
  task automatic send(logic [1:0] cmd, logic [7:0] id, logic [7:0] prio);
    s_tuser  <= cmd;
    s_tdata  <= {prio, id};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    n_sent[cmd]++;
    if (!idle_off && $urandom_range(0, 99) < 30) begin
      s_tvalid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  // Result side backpressure
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (!idle_off && $urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    logic [1:0] cmd;
    logic [7:0] id, prio;
    int         roll, w_enq, w_deq, w_purge;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part: corner statuses on an empty queue, the unused code
    send(CMD_DEQUEUE, 8'hFF, 8'hFF);   // dequeue on empty, fields ignored
    send(CMD_PURGE, 8'h00, 8'hFF);     // purge on empty -> not found
    send(CMD_UNUSED, 8'hAA, 8'h55);

    // Fill to capacity: priorities 0/100/255 repeat so ties must stay FIFO,
    // ids span 0..255 and one id is stored twice
    for (int i = 0; i < DEPTH; i++) begin
      id = (i == 12) ? 8'd51 : 8'(i * 17);
      case (i % 4)
        0:       prio = 8'd255;
        1:       prio = 8'd0;
        default: prio = 8'd100;
      endcase
      send(CMD_ENQUEUE, id, prio);
    end
    send(CMD_ENQUEUE, 8'h77, 8'h00);   // full: dropped
    send(CMD_UNUSED, 8'h00, 8'h00);    // reports a full count
    send(CMD_PURGE, 8'h5A, 8'hFF);     // id not stored
    send(CMD_PURGE, 8'd51, 8'h00);     // duplicate id: first from head leaves
    send(CMD_PURGE, 8'd255, 8'h00);
    send(CMD_DEQUEUE, 8'h00, 8'h00);

    // Random part: phases leaning to fill, drain or balance so the queue
    // swings between empty and full. Ids mostly from a small pool so purges
    // hit; priorities often from a narrow range to make ties.
    for (int phase = 0; phase < 9; phase++) begin
      case (phase % 3)
        0: begin
          w_enq = 60; w_deq = 15; w_purge = 20;
        end
        1: begin
          w_enq = 20; w_deq = 50; w_purge = 27;
        end
        default: begin
          w_enq = 40; w_deq = 28; w_purge = 28;
        end
      endcase
      idle_off = (phase % 4 == 3);
      for (int k = 0; k < 50; k++) begin
        roll = $urandom_range(0, 99);
        id   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
        prio = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
        if (roll < w_enq)                      cmd = CMD_ENQUEUE;
        else if (roll < w_enq + w_deq)         cmd = CMD_DEQUEUE;
        else if (roll < w_enq + w_deq + w_purge) cmd = CMD_PURGE;
        else                                   cmd = CMD_UNUSED;
        send(cmd, id, prio);
      end
    end
    s_tvalid <= 1'b0;
    idle_off  = 1'b0;

    // Let every outstanding result drain, then watch for strays. The wait starts
    // on a clock edge so the pending count includes the last accepted transaction.
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Drove %0d transactions: %0d enqueue, %0d dequeue, %0d purge, %0d unused code",
             n_sent[0] + n_sent[1] + n_sent[2] + n_sent[3],
             n_sent[CMD_ENQUEUE], n_sent[CMD_DEQUEUE], n_sent[CMD_PURGE],
             n_sent[CMD_UNUSED]);
    $display("Compared %0d results: %0d dropped when full, %0d empty dequeues, %0d purge misses",
             n_results, n_full, n_empty, n_not_found);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/sprq_pkg.sv
design/sprq_datapath.sv
design/sprq_ctrl.sv
design/sorted_priority_ready_queue.sv
bench/sprq_result_checker.sv
bench/sorted_priority_ready_queue_test.sv
